/* rtl/trd_pkg.sv */
// Shared types and constants of the Targa RLE packet decoder.
package trd_pkg;

  // Packet header codes and pixel size.
  localparam logic [7:0] RUN_MARK   = 8'd128;
  localparam logic [7:0] RUN_BIAS   = 8'd127;
  localparam logic [2:0] BGRA_BYTES = 3'd4;

  // Default width of the decoded pixel counter.
  localparam int unsigned COUNT_BITS_DEF = 24;

  // Configuration port geometry.
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned TOTAL_W = 24;

  // Reset values of the configuration registers.
  localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 24'd1;

  // Register index, taken from the word address.
  typedef enum logic {
    REG_BPP   = 1'b0,
    REG_TOTAL = 1'b1
  } reg_idx_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic [TOTAL_W-1:0] pixel_total;
  } cfg_t;

  // One compressed byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } pix_in_t;

  // One decoded colour with its repeat count.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       clipped;
  } pix_out_t;

endpackage

/* rtl/tga_rle_packet_decoder.sv */
// Top level of the Targa RLE packet decoder: input stage, packet decode and result register.
//
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid_i / in_stall_o   in_req_i  (pix_in_t)
//  out      output     out_valid_o / out_stall_i out_req_o (pix_out_t)
//  config   input      APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One byte is taken per cycle while in_stall_o is low; a request waits in the input register
// and its result is written into the result register when the decode step fires.
// The decode step itself is a single pass: one COUNT_BITS-wide subtract, compare and add.
// Reset clears all decoding state and sets 4 bytes per pixel and a total of one pixel.
// A stalled result holds the input register only when that byte produces a result.
module tga_rle_packet_decoder import trd_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pix_in_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pix_out_t          out_req_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned TW = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  cfg_t cfg;

  // Input stage.
  logic    s1_valid_q;
  pix_in_t s1_q;
  logic    in_accept;
  logic    exe_fire;

  // Decoding state.
  logic                  exp_q, exp_d;
  logic                  run_q, run_d;
  logic [7:0]            left_q, left_d;
  logic [1:0]            bip_q, bip_d;
  logic [7:0]            hb_q, hb_d, hg_q, hg_d, hr_q, hr_d;
  logic [COUNT_BITS-1:0] dec_q, dec_d;
  logic                  fin_q, fin_d;

  // Result register.
  logic     out_valid_q;
  pix_out_t out_q;
  pix_out_t res;
  logic     res_valid;
  logic     out_free;

  // Step intermediates.
  logic [TW-1:0]         total_ext, cmax_ext, total_tw;
  logic [COUNT_BITS-1:0] total, remaining, cand_ext;
  logic [1:0]            last_pos;
  logic [7:0]            cand, emitted;
  logic                  done;

  trd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the held byte moves on unless it has a result and the output is full and stalled.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exe_fire   = s1_valid_q && (!res_valid || out_free);
  assign in_stall_o = s1_valid_q && !exe_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Effective total, limited to what the counter can hold.
  assign total_ext = TW'(cfg.pixel_total);
  assign cmax_ext  = TW'({COUNT_BITS{1'b1}});
  assign total_tw  = (total_ext > cmax_ext) ? cmax_ext : total_ext;
  assign total     = total_tw[COUNT_BITS-1:0];
  assign last_pos  = (cfg.bytes_per_pixel == BGRA_BYTES) ? 2'd3 : 2'd2;

  // Packet decode for the byte in the input register.
  always_comb begin
    if (s1_q.frame_start) begin
      exp_d = 1'b1; run_d = 1'b0; left_d = '0; bip_d = '0;
      hb_d = '0; hg_d = '0; hr_d = '0; dec_d = '0; fin_d = 1'b0;
    end else begin
      exp_d = exp_q; run_d = run_q; left_d = left_q; bip_d = bip_q;
      hb_d = hb_q; hg_d = hg_q; hr_d = hr_q; dec_d = dec_q; fin_d = fin_q;
    end
    res_valid = 1'b0;
    res       = '0;
    remaining = total - dec_d;
    cand      = run_d ? left_d : 8'd1;
    cand_ext  = COUNT_BITS'(cand);
    emitted   = (cand_ext > remaining) ? remaining[7:0] : cand;
    done      = (COUNT_BITS'(emitted) == remaining);

    if (!fin_d) begin
      if (dec_d >= total) begin
        // Total already reached: stop and ignore the byte.
        fin_d  = 1'b1;
        exp_d  = 1'b1;
        left_d = '0;
        bip_d  = '0;
      end else if (exp_d) begin
        // Packet header.
        run_d  = (s1_q.data_byte >= RUN_MARK);
        left_d = (s1_q.data_byte >= RUN_MARK) ? (s1_q.data_byte - RUN_BIAS)
                                              : (s1_q.data_byte + 8'd1);
        exp_d  = 1'b0;
        bip_d  = '0;
      end else if (bip_d < last_pos) begin
        // Colour byte inside a pixel.
        case (bip_d)
          2'd0:    hb_d = s1_q.data_byte;
          2'd1:    hg_d = s1_q.data_byte;
          default: hr_d = s1_q.data_byte;
        endcase
        bip_d = bip_d + 2'd1;
      end else begin
        // Last byte of the pixel: issue the colour and its count.
        if (last_pos == 2'd2 && bip_d == 2'd2) begin
          hr_d = s1_q.data_byte;
        end
        res_valid        = 1'b1;
        res.blue         = hb_d;
        res.green        = hg_d;
        res.red          = hr_d;
        res.alpha        = (last_pos == 2'd3) ? s1_q.data_byte : 8'd0;
        res.repeat_count = emitted;
        res.image_done   = done;
        res.clipped      = done && (run_d ? (left_d != emitted) : (left_d != 8'd1));
        dec_d  = dec_d + COUNT_BITS'(emitted);
        bip_d  = '0;
        left_d = run_d ? 8'd0 : (left_d - 8'd1);
        if (left_d == 8'd0) begin
          exp_d = 1'b1;
        end
        if (done) begin
          fin_d  = 1'b1;
          exp_d  = 1'b1;
          left_d = '0;
        end
      end
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      exp_q  <= 1'b1;
      run_q  <= 1'b0;
      left_q <= '0;
      bip_q  <= '0;
      hb_q   <= '0;
      hg_q   <= '0;
      hr_q   <= '0;
      dec_q  <= '0;
      fin_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (exe_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (exe_fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (exe_fire) begin
        exp_q  <= exp_d;
        run_q  <= run_d;
        left_q <= left_d;
        bip_q  <= bip_d;
        hb_q   <= hb_d;
        hg_q   <= hg_d;
        hr_q   <= hr_d;
        dec_q  <= dec_d;
        fin_q  <= fin_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_req_i;
    end
    if (exe_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.repeat_count != 8'd0)
    else $error("result with zero repeat count");

  a_clip_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.clipped |-> out_req_o.image_done)
    else $error("clipped result without image end");

  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && fin_q && !s1_q.frame_start |-> !res_valid)
    else $error("result after image end");

  a_end_sets_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exe_fire && res_valid && res.image_done |=> fin_q)
    else $error("image end not recorded");

  a_packet_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exp_q |-> left_q != 8'd0)
    else $error("open packet with no pixels left");
`endif

endmodule

/* rtl/trd_regs.sv */
// Configuration register file of the Targa RLE packet decoder on an APB-style port.
module trd_regs import trd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [BPP_W-1:0]   bpp_q, bpp_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  reg_idx_e           idx;
  logic               wr_en;

  // Registers sit on 32-bit words, so bit 2 picks the register.
  assign idx    = reg_idx_e'(paddr[ADDR_W-1]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write decode.
  always_comb begin
    bpp_d   = bpp_q;
    total_d = total_q;
    if (wr_en) begin
      unique case (idx)
        REG_BPP:   bpp_d   = pwdata[BPP_W-1:0];
        REG_TOTAL: total_d = pwdata[TOTAL_W-1:0];
        default:   bpp_d   = bpp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BPP_RESET;
      total_q <= TOTAL_RESET;
    end else begin
      bpp_q   <= bpp_d;
      total_q <= total_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      REG_BPP:   prdata = DATA_W'(bpp_q);
      REG_TOTAL: prdata = DATA_W'(total_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.bytes_per_pixel = bpp_q;
  assign cfg_o.pixel_total     = total_q;

endmodule

/* test/testbench.sv */
// Self-checking testbench of the Targa RLE packet decoder with a predicting scoreboard.
`timescale 1ns / 100ps

module testbench;
  import trd_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 900;
  localparam int unsigned IDLE_PCT        = 8;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned PRINT_LIMIT     = 50;

  // Decodes accepted requests into expected pixels and checks the block's results.
  class pixel_scoreboard;
    logic [BPP_W-1:0]          bpp;
    logic [TOTAL_W-1:0]        total;
    bit                        want_header;
    bit                        in_run;
    bit                        done_flag;
    logic [7:0]                pixels_left;
    logic [1:0]                byte_pos;
    logic [7:0]                blue_q;
    logic [7:0]                green_q;
    logic [7:0]                red_q;
    logic [COUNT_BITS_DEF-1:0] decoded;
    pix_out_t                  expected_pixels[$];
    int                        errors;
    int                        consumed;

    function new();
      bpp      = BPP_RESET;
      total    = TOTAL_RESET;
      errors   = 0;
      consumed = 0;
      clear_image();
    endfunction

    function void clear_image();
      want_header = 1'b1;
      in_run      = 1'b0;
      done_flag   = 1'b0;
      pixels_left = '0;
      byte_pos    = '0;
      blue_q      = '0;
      green_q     = '0;
      red_q       = '0;
      decoded     = '0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
      if (idx == REG_BPP) begin
        bpp = value[BPP_W-1:0];
      end else begin
        total = value[TOTAL_W-1:0];
      end
    endfunction

    // Advances the decoder copy by one accepted byte and queues the pixel it completes.
    function void decode_request(pix_in_t req);
      logic [1:0]                last_pos;
      logic [COUNT_BITS_DEF-1:0] remaining;
      logic [COUNT_BITS_DEF-1:0] emitted;
      int                        rest;
      pix_out_t                  pix;
      if (req.frame_start) begin
        clear_image();
      end
      if (done_flag) begin
        return;
      end
      // A total at or below the decoded count ends the image without a result.
      if (decoded >= total) begin
        done_flag   = 1'b1;
        want_header = 1'b1;
        pixels_left = '0;
        byte_pos    = '0;
        return;
      end
      consumed++;
      last_pos = (bpp == BGRA_BYTES) ? 2'd3 : 2'd2;
      if (want_header) begin
        in_run      = (req.data_byte >= RUN_MARK);
        pixels_left = in_run ? req.data_byte - RUN_BIAS : req.data_byte + 8'd1;
        want_header = 1'b0;
        byte_pos    = '0;
        return;
      end
      if (byte_pos < last_pos) begin
        case (byte_pos)
          2'd0: blue_q = req.data_byte;
          2'd1: green_q = req.data_byte;
          default: red_q = req.data_byte;
        endcase
        byte_pos++;
        return;
      end
      // This byte completes the pixel; a size change may leave red as it was.
      if (last_pos == 2'd2 && byte_pos == 2'd2) begin
        red_q = req.data_byte;
      end
      remaining = total - decoded;
      emitted   = in_run ? COUNT_BITS_DEF'(pixels_left) : COUNT_BITS_DEF'(1);
      if (emitted > remaining) begin
        emitted = remaining;
      end
      rest             = int'(pixels_left) - (in_run ? int'(emitted) : 1);
      pix.blue         = blue_q;
      pix.green        = green_q;
      pix.red          = red_q;
      pix.alpha        = (last_pos == 2'd3) ? req.data_byte : 8'd0;
      pix.repeat_count = emitted[7:0];
      pix.image_done   = (emitted == remaining);
      pix.clipped      = pix.image_done && (rest > 0);
      expected_pixels.push_back(pix);
      decoded  = decoded + emitted;
      byte_pos = '0;
      if (in_run) begin
        pixels_left = '0;
      end else begin
        pixels_left--;
      end
      if (pixels_left == 0) begin
        want_header = 1'b1;
      end
      if (pix.image_done) begin
        done_flag   = 1'b1;
        want_header = 1'b1;
        pixels_left = '0;
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= PRINT_LIMIT) begin
          $display("%0t: %s differs, expected %0d, actual %0d", $time, field, want, got);
        end
      end
    endfunction

    // Checks one accepted result against the oldest expected pixel.
    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT) begin
          $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
        end
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("blue", want.blue, got.blue);
      compare_field("green", want.green, got.green);
      compare_field("red", want.red, got.red);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("repeat_count", want.repeat_count, got.repeat_count);
      compare_field("image_done", 8'(want.image_done), 8'(got.image_done));
      compare_field("clipped", 8'(want.clipped), 8'(got.clipped));
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  pix_in_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pix_out_t          out_req_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pixel_scoreboard sb = new();
  int unsigned     idle_pct = IDLE_PCT;
  int unsigned     hold_req = 0;
  int unsigned     quiet_cycles = 0;

  tga_rle_packet_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk_i = ~clk_i;

  // Offers one byte, with an occasional gap before it, until the block takes it.
  task automatic send_byte(input logic [7:0] data, input logic fs);
    pix_in_t req;
    bit      taken;
    req.data_byte   = data;
    req.frame_start = fs;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do begin
      @(negedge clk_i);
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        sb.decode_request(req);
      end
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Stops sending until every expected pixel has come out and the pipeline is empty.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    bit written;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      written = pready;
      @(posedge clk_i);
    end while (!written);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits for the block to drain, then writes both registers with junk in the unused upper bits.
  task automatic configure(input logic [BPP_W-1:0] bpp, input logic [TOTAL_W-1:0] total);
    pause_until_drained();
    write_reg(REG_BPP, ($urandom & ~32'h7) | DATA_W'(bpp));
    write_reg(REG_TOTAL, ($urandom & 32'hFF00_0000) | DATA_W'(total));
  endtask

  // Sends well-formed packets of a new image, sometimes cut short, sometimes with trailing bytes.
  task automatic send_frame(input int max_packets);
    logic [7:0] hdr;
    int         pixel_bytes;
    int         npix;
    for (int p = 0; p < max_packets && (p == 0 || !sb.done_flag); p++) begin
      if ($urandom_range(1)) begin
        hdr = 8'($urandom_range(255, 128));
      end else if ($urandom_range(24) == 0) begin
        hdr = 8'($urandom_range(127));
      end else begin
        hdr = 8'($urandom_range(5));
      end
      send_byte(hdr, p == 0);
      pixel_bytes = (sb.bpp == BGRA_BYTES) ? 4 : 3;
      npix        = (hdr >= RUN_MARK) ? 1 : int'(hdr) + 1;
      // A broken packet leaves the decoder mid-pixel for the next image.
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
        return;
      end
      repeat (npix * pixel_bytes) begin
        send_byte(8'($urandom), 1'b0);
        if (sb.done_flag) break;
      end
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Result side: random stalls, or a long hold-off when requested.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Result check and watchdog, sampled on the falling edge before the accepting edge.
  always @(negedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_pixel(out_req_o);
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [BPP_W-1:0]   bpp;
    logic [TOTAL_W-1:0] total;
    int                 target;
    bit                 paused;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a full run of 128 against a total of one pixel is clipped.
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h12, 1'b0);

    // Three-byte pixels, largest total, a raw packet of two pixels.
    configure(3'd3, 24'hFF_FFFF);
    send_byte(8'h01, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'hFC, 1'b0);

    // An odd pixel size means three bytes; the second run passes the end.
    configure(3'd7, 24'd5);
    send_byte(8'h83, 1'b1);
    repeat (3) send_byte(8'($urandom), 1'b0);
    send_byte(8'h82, 1'b0);
    repeat (3) send_byte(8'($urandom), 1'b0);
    send_byte(8'h33, 1'b0);

    // Pixel size drops from four to three after the red byte.
    configure(3'd4, 24'd100);
    send_byte(8'h02, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    configure(3'd3, 24'd100);
    send_byte(8'h44, 1'b0);

    // Total lowered to the decoded count in mid-image, then a zero total.
    configure(3'd0, 24'd1);
    send_byte(8'h55, 1'b0);
    configure(3'd0, 24'd0);
    send_byte(8'h80, 1'b1);

    // Random images under random settings, with pressure in some phases.
    for (int phase = 0; sb.consumed < RANDOM_REQUESTS; phase++) begin
      if ($urandom_range(3) == 0) begin
        bpp = 3'($urandom_range(7));
      end else begin
        bpp = $urandom_range(1) ? 3'd4 : 3'd3;
      end
      case ($urandom_range(5))
        0: total = 24'd1;
        1: total = 24'hFF_FFFF;
        default: total = 24'($urandom_range(1, 60));
      endcase
      if (phase == 3) begin
        total = 24'd1000;
      end
      configure(bpp, total);
      idle_pct = (phase == 2) ? 0 : IDLE_PCT;
      if (phase == 3) begin
        hold_req = HOLD_CYCLES;
      end
      target = sb.consumed + 150;
      while (sb.consumed < target) begin
        if ($urandom_range(9) == 0) begin
          send_byte(8'($urandom), 1'($urandom_range(1)));
        end else begin
          send_frame($urandom_range(1, 8));
        end
        if (phase == 4 && !paused && sb.consumed >= target - 75) begin
          pause_until_drained();
          paused = 1'b1;
        end
      end
    end

    pause_until_drained();
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
